@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define BFHA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define BFHA_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the next cycle.
`define BFHA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bfha_pkg.sv @@
`default_nettype none
package bfha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 256;
  localparam int ALIGN_BYTES  = 8;

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int SZ_W   = 18;
  localparam int CMP_W  = 19;
  localparam int CNT_W  = 9;
  localparam int TOT_W  = 64;

  // Operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic              has_address;
    logic [OFF_W-1:0]  payload_address;
    logic [SIZE_W-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_address;
    logic             success;
    logic [TOT_W-1:0] allocated_total;
    logic [TOT_W-1:0] freed_total;
    logic [CNT_W-1:0] block_count;
  } rsp_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              free;
    logic [IDX_W-1:0]  next;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ src/bfha_ram.sv @@
`default_nettype none
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/best_fit_heap_allocator.sv @@
// Best-fit heap allocator, metadata only.
// Input channel: in_valid_i / in_stall_o carry one request item (allocate, free or
// resize). Output channel: out_valid_o / out_stall_i carry one result item per
// request, with the returned payload offset, a success flag and the running totals.
// The block table sits in one 256-entry memory with a registered read; the list is
// walked one entry per cycle. A zero-size allocate, a null free or an unused code
// goes straight to the result stage; any other item first does a lookup or
// best-fit walk over the blocks, then a spare-entry scan on a split, and a
// coalescing walk after a free; a resize that moves does all of these.
// Items are handled one at a time; in_stall_o is low only while the sequencer is
// idle, so the next item is taken the cycle after a result has been loaded.
// After reset the init state writes the head entry (whole heap, free) with in_stall_o
// high; totals are zero and the block count is one.
// A finished result waits in the output register while out_stall_i is high; the
// next item is already accepted meanwhile, and its own result waits until the
// register has been taken.
`default_nettype none
module best_fit_heap_allocator
  import bfha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_item_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_item_o
);

`include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_EX, S_A_END, S_F_RD, S_F_EX, S_R_CHK, S_R_NX,
    S_SPL_CHK, S_SPL_SCAN, S_FIN, S_FREE, S_M_RDC, S_M_LDC, S_M_EX, S_M_WB, S_DONE
  } state_e;

  typedef enum logic [1:0] {C_ALLOC, C_SHRINK, C_GROW} ctx_e;

  localparam logic [SIZE_W-1:0] HDR17    = SIZE_W'(HEADER_BYTES);
  localparam logic [CMP_W-1:0]  SPLIT_MIN = CMP_W'(HEADER_BYTES + ALIGN_BYTES);
  localparam logic [SZ_W-1:0]   ALIGN_M  = SZ_W'(ALIGN_BYTES - 1);

  state_e              state_q;
  ctx_e                ctx_q;
  req_t                req_q;
  logic [SZ_W-1:0]     sz_q;
  logic [IDX_W-1:0]    cur_q;
  entry_t              best_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic                have_best_q;
  entry_t              tgt_q;
  logic [IDX_W-1:0]    tgt_idx_q;
  entry_t              ob_q;
  logic [IDX_W-1:0]    ob_idx_q;
  logic [SIZE_W-1:0]   old_size_q;
  logic                move_q;
  logic                split_q;
  logic [IDX_W-1:0]    scan_q;
  logic [MAX_BLOCKS-1:0] spare_q;
  logic [CNT_W-1:0]    live_q;
  logic [TOT_W-1:0]    alloc_q;
  logic [TOT_W-1:0]    freed_q;
  logic [OFF_W-1:0]    addr_q;
  logic                ok_q;
  entry_t              cm_q;
  logic [IDX_W-1:0]    c_idx_q;
  rsp_t                out_q;
  logic                out_valid_q;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [IDX_W-1:0]    mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;
  entry_t              rd_e;
  logic [SZ_W-1:0]     in_sz;
  logic                fit;
  logic                better;
  logic                merge_now;
  logic [SIZE_W-1:0]   grow_size;
  entry_t              new_e;

  assign rd_e = entry_t'(mem_rdata);

  bfha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Derive rounded size, fit tests and the split remainder
  always_comb begin
    in_sz     = ({1'b0, in_item_i.request_bytes} + ALIGN_M) & ~ALIGN_M;
    fit       = rd_e.free && ({1'b0, rd_e.size} >= sz_q);
    better    = fit && (!have_best_q || (rd_e.size < best_q.size));
    merge_now = cm_q.free && rd_e.free;
    grow_size = tgt_q.size + HDR17 + rd_e.size;
    new_e.offset = OFF_W'({1'b0, tgt_q.offset} + HDR17 + sz_q);
    new_e.size   = SIZE_W'({1'b0, tgt_q.size} - sz_q - {1'b0, HDR17});
    new_e.free   = 1'b1;
    new_e.next   = tgt_q.next;
  end

  // Drive the table ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tgt_idx_q;
    mem_wdata = tgt_q;
    mem_raddr = '0;
    unique case (state_q)
      S_INIT: begin
        mem_we           = 1'b1;
        mem_waddr        = '0;
        mem_wdata.offset = '0;
        mem_wdata.size   = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
        mem_wdata.free   = 1'b1;
        mem_wdata.next   = '0;
      end
      S_A_EX, S_F_EX, S_M_LDC, S_M_EX: begin
        mem_raddr = rd_e.next;
        if (state_q == S_M_EX && !merge_now) begin
          mem_we    = 1'b1;
          mem_waddr = c_idx_q;
          mem_wdata = cm_q;
        end
      end
      S_R_CHK: mem_raddr = tgt_q.next;
      S_SPL_SCAN: begin
        mem_we    = spare_q[scan_q];
        mem_waddr = scan_q;
        mem_wdata = new_e;
      end
      S_FIN: begin
        mem_we = 1'b1;
        if (ctx_q == C_ALLOC) begin
          mem_wdata.free = 1'b0;
        end
      end
      S_FREE: begin
        mem_we         = 1'b1;
        mem_wdata.free = 1'b1;
      end
      S_M_WB: begin
        mem_we    = 1'b1;
        mem_waddr = c_idx_q;
        mem_wdata = cm_q;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequence the operations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      spare_q     <= {{(MAX_BLOCKS-1){1'b1}}, 1'b0};
      live_q      <= CNT_W'(1);
      alloc_q     <= '0;
      freed_q     <= '0;
      out_valid_q <= 1'b0;
      have_best_q <= 1'b0;
      move_q      <= 1'b0;
      split_q     <= 1'b0;
      ok_q        <= 1'b0;
      ctx_q       <= C_ALLOC;
    end else begin
      // Drop a result once taken, unless a new one loads now
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: state_q <= S_IDLE;
        S_IDLE: begin
          if (in_valid_i) begin
            req_q       <= in_item_i;
            sz_q        <= in_sz;
            addr_q      <= '0;
            ok_q        <= 1'b0;
            move_q      <= 1'b0;
            have_best_q <= 1'b0;
            cur_q       <= '0;
            priority case (in_item_i.operation)
              OP_ALLOC: begin
                state_q <= (in_item_i.request_bytes == '0) ? S_DONE : S_A_RD;
              end
              OP_FREE: begin
                if (!in_item_i.has_address) begin
                  ok_q    <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_F_RD;
                end
              end
              OP_RESIZE: begin
                if (in_item_i.has_address) begin
                  state_q <= S_F_RD;
                end else begin
                  state_q <= (in_item_i.request_bytes == '0) ? S_DONE : S_A_RD;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        // Best-fit walk, one entry a cycle
        S_A_RD: state_q <= S_A_EX;
        S_A_EX: begin
          if (better) begin
            best_q      <= rd_e;
            best_idx_q  <= cur_q;
            have_best_q <= 1'b1;
          end
          if ((better && ({1'b0, rd_e.size} == sz_q)) || rd_e.next == '0) begin
            state_q <= S_A_END;
          end else begin
            cur_q <= rd_e.next;
          end
        end
        S_A_END: begin
          if (!have_best_q) begin
            state_q <= S_DONE;
          end else begin
            tgt_q     <= best_q;
            tgt_idx_q <= best_idx_q;
            ctx_q     <= C_ALLOC;
            state_q   <= S_SPL_CHK;
          end
        end
        // Look up an allocated block by payload offset
        S_F_RD: state_q <= S_F_EX;
        S_F_EX: begin
          if (!rd_e.free && ({1'b0, rd_e.offset} + HDR17) ==
              {1'b0, req_q.payload_address}) begin
            tgt_q     <= rd_e;
            tgt_idx_q <= cur_q;
            if (req_q.operation == OP_FREE || req_q.request_bytes == '0) begin
              ok_q    <= 1'b1;
              state_q <= S_FREE;
            end else begin
              state_q <= S_R_CHK;
            end
          end else if (rd_e.next == '0) begin
            state_q <= S_DONE;
          end else begin
            cur_q <= rd_e.next;
          end
        end
        // Resize: shrink, grow into successor, or move
        S_R_CHK: begin
          old_size_q <= tgt_q.size;
          ob_q       <= tgt_q;
          ob_idx_q   <= tgt_idx_q;
          if ({1'b0, tgt_q.size} >= sz_q) begin
            ctx_q   <= C_SHRINK;
            state_q <= S_SPL_CHK;
          end else if (tgt_q.next != '0) begin
            state_q <= S_R_NX;
          end else begin
            move_q  <= 1'b1;
            cur_q   <= '0;
            state_q <= S_A_RD;
          end
        end
        S_R_NX: begin
          if (rd_e.free && ({1'b0, grow_size} >= sz_q)) begin
            tgt_q.size          <= grow_size;
            tgt_q.next          <= rd_e.next;
            spare_q[tgt_q.next] <= 1'b1;
            live_q              <= live_q - CNT_W'(1);
            ctx_q               <= C_GROW;
            state_q             <= S_SPL_CHK;
          end else begin
            move_q  <= 1'b1;
            cur_q   <= '0;
            state_q <= S_A_RD;
          end
        end
        // Split off the remainder when room and a spare entry allow
        S_SPL_CHK: begin
          split_q <= 1'b0;
          scan_q  <= IDX_W'(1);
          if ({2'b0, tgt_q.size} < ({1'b0, sz_q} + SPLIT_MIN)) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_SPL_SCAN;
          end
        end
        S_SPL_SCAN: begin
          if (spare_q[scan_q]) begin
            spare_q[scan_q] <= 1'b0;
            tgt_q.next      <= scan_q;
            tgt_q.size      <= SIZE_W'(sz_q);
            live_q          <= live_q + CNT_W'(1);
            split_q         <= 1'b1;
            state_q         <= S_FIN;
          end else if (scan_q == IDX_W'(MAX_BLOCKS - 1)) begin
            state_q <= S_FIN;
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        // Write back the target and settle the totals
        S_FIN: begin
          ok_q   <= 1'b1;
          addr_q <= OFF_W'({1'b0, tgt_q.offset} + HDR17);
          unique case (ctx_q)
            C_ALLOC: begin
              alloc_q <= alloc_q + TOT_W'(tgt_q.size);
              if (move_q) begin
                tgt_q     <= ob_q;
                tgt_idx_q <= ob_idx_q;
                state_q   <= S_FREE;
              end else begin
                state_q <= S_DONE;
              end
            end
            C_SHRINK: begin
              if (split_q) begin
                freed_q <= freed_q + TOT_W'({1'b0, old_size_q} - sz_q);
                state_q <= S_M_RDC;
              end else begin
                state_q <= S_DONE;
              end
            end
            C_GROW: begin
              alloc_q <= alloc_q + TOT_W'(sz_q - {1'b0, old_size_q});
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_FREE: begin
          freed_q <= freed_q + TOT_W'(tgt_q.size);
          state_q <= S_M_RDC;
        end
        // Coalescing walk from the head
        S_M_RDC: begin
          c_idx_q <= '0;
          state_q <= S_M_LDC;
        end
        S_M_LDC: begin
          cm_q    <= rd_e;
          state_q <= (rd_e.next == '0) ? S_DONE : S_M_EX;
        end
        S_M_EX: begin
          if (merge_now) begin
            cm_q.size          <= cm_q.size + HDR17 + rd_e.size;
            cm_q.next          <= rd_e.next;
            spare_q[cm_q.next] <= 1'b1;
            live_q             <= live_q - CNT_W'(1);
            if (rd_e.next == '0) begin
              state_q <= S_M_WB;
            end
          end else begin
            cm_q    <= rd_e;
            c_idx_q <= cm_q.next;
            if (rd_e.next == '0) begin
              state_q <= S_DONE;
            end
          end
        end
        S_M_WB: state_q <= S_DONE;
        // Hand the result to the output register
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.result_address  <= addr_q;
            out_q.success         <= ok_q;
            out_q.allocated_total <= alloc_q;
            out_q.freed_total     <= freed_q;
            out_q.block_count     <= live_q;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `BFHA_ASSERT(a_live_range, (live_q != '0) && (live_q <= CNT_W'(MAX_BLOCKS)), "block count out of range")
  `BFHA_ASSERT(a_head_kept, !spare_q[0], "head entry marked spare")
  `BFHA_IMPLY(a_fail_zero, out_valid_q && !out_q.success, out_q.result_address == '0, "failed item returns an address")
  `BFHA_NEXT(a_done_loads, (state_q == S_DONE) && (!out_valid_q || !out_stall_i), out_valid_q && (state_q == S_IDLE), "result not loaded")

endmodule
`default_nettype wire
